// ===== hdl/rbc_pkg.sv =====
package rbc_pkg;

  // Default sizes
  localparam int DEF_CHANNELS   = 4;
  localparam int DEF_DELAY_BITS = 32;

  // Wide intermediate for delay math and the exponential cap
  localparam int SHIFT_W = 64;
  localparam int EXP_CAP = 48;

  // Commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_REPLY = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Channel phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_REPLY   = 2'd1;
  localparam logic [1:0] PH_BACKOFF = 2'd2;

  // Event kinds
  localparam logic [1:0] EV_SEND   = 2'd0;
  localparam logic [1:0] EV_DONE   = 2'd1;
  localparam logic [1:0] EV_GIVEUP = 2'd2;

  // Retry modes
  localparam logic [2:0] MODE_NEVER  = 3'd0;
  localparam logic [2:0] MODE_IMMED  = 3'd1;
  localparam logic [2:0] MODE_LINEAR = 3'd2;
  localparam logic [2:0] MODE_EXP    = 3'd3;
  localparam logic [2:0] MODE_FIXED  = 3'd4;

  // Reply status codes
  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_ACK     = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_PARAM   = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_RETRY_MODE  = 2'd0;
  localparam logic [1:0] CFG_MAX_RETRIES = 2'd1;
  localparam logic [1:0] CFG_REPLY_TMO   = 2'd2;
  localparam logic [1:0] CFG_BACKOFF_U   = 2'd3;

  // Configuration reset values
  localparam logic [2:0]  RST_RETRY_MODE  = MODE_IMMED;
  localparam logic [7:0]  RST_MAX_RETRIES = 8'd3;
  localparam logic [15:0] RST_REPLY_TMO   = 16'd1000;
  localparam logic [15:0] RST_BACKOFF_U   = 16'd1000;

  // Decision of the channel step unit for one visited channel
  typedef struct packed {
    logic       ev_valid;
    logic [1:0] ev_kind;
    logic [1:0] phase_nxt;
    logic       dec_reply;
    logic       dec_backoff;
    logic       load_send;
    logic       bump_retry;
    logic       need_delay;
  } step_ctl_t;

endpackage

// ===== hdl/rbc_step.sv =====
module rbc_step import rbc_pkg::*; #(
  parameter int DELAY_BITS = DEF_DELAY_BITS
) (
  input  logic [1:0]            phase,
  input  logic [15:0]           reply_cd,
  input  logic [DELAY_BITS-1:0] backoff_cd,
  input  logic [7:0]            retry_cnt,
  input  logic [2:0]            status,
  input  logic [2:0]            retry_mode,
  input  logic [7:0]            max_retries,
  output step_ctl_t             ctl
);

  // Advance one channel by one tick
  always_comb begin
    ctl           = '0;
    ctl.phase_nxt = phase;
    unique case (phase)
      PH_REPLY: begin
        if (reply_cd > 16'd1) begin
          ctl.dec_reply = 1'b1;
        end else if (status == ST_ACK || status == ST_UNKNOWN || status > ST_PARAM) begin
          // reply ends the transaction
          ctl.ev_valid  = 1'b1;
          ctl.ev_kind   = EV_DONE;
          ctl.phase_nxt = PH_IDLE;
        end else if (retry_mode == MODE_NEVER || retry_mode > MODE_FIXED ||
                     retry_cnt >= max_retries) begin
          ctl.ev_valid  = 1'b1;
          ctl.ev_kind   = EV_GIVEUP;
          ctl.phase_nxt = PH_IDLE;
        end else begin
          ctl.bump_retry = 1'b1;
          if (retry_mode == MODE_IMMED) begin
            ctl.ev_valid  = 1'b1;
            ctl.ev_kind   = EV_SEND;
            ctl.load_send = 1'b1;
            ctl.phase_nxt = PH_REPLY;
          end else begin
            ctl.phase_nxt  = PH_BACKOFF;
            ctl.need_delay = 1'b1;
          end
        end
      end
      PH_BACKOFF: begin
        if (backoff_cd > DELAY_BITS'(1)) begin
          ctl.dec_backoff = 1'b1;
        end else begin
          // backoff over: resend
          ctl.ev_valid  = 1'b1;
          ctl.ev_kind   = EV_SEND;
          ctl.load_send = 1'b1;
          ctl.phase_nxt = PH_REPLY;
        end
      end
      default: begin
        ctl.phase_nxt = phase;
      end
    endcase
  end

endmodule

// ===== hdl/rbc_delay.sv =====
module rbc_delay import rbc_pkg::*; #(
  parameter int DELAY_BITS = DEF_DELAY_BITS
) (
  input  logic [2:0]            retry_mode,
  input  logic [15:0]           unit_ticks,
  input  logic [7:0]            retry_cnt,
  output logic [DELAY_BITS-1:0] delay
);

  logic [23:0]        prod;
  logic [SHIFT_W-1:0] shl;
  logic [SHIFT_W-1:0] wide;

  // Raw delay by mode
  always_comb begin
    prod = 24'(unit_ticks) * 24'(retry_cnt);
    shl  = SHIFT_W'(unit_ticks) << retry_cnt[5:0];
    case (retry_mode)
      MODE_LINEAR: wide = SHIFT_W'(prod);
      MODE_EXP:    wide = (retry_cnt >= 8'(EXP_CAP)) ? '1 : shl;
      default:     wide = SHIFT_W'(unit_ticks);
    endcase
  end

  // Saturate at the timer maximum, never load zero
  always_comb begin
    if (|(wide >> DELAY_BITS)) begin
      delay = '1;
    end else if (wide == '0) begin
      delay = DELAY_BITS'(1);
    end else begin
      delay = wide[DELAY_BITS-1:0];
    end
  end

endmodule

// ===== hdl/retransmit_backoff_controller.sv =====
// Retransmission controller with backoff, one exchange per channel.
// Input channel: start/busy command handshake; an input transaction is a start
// request, a reply status, or one timer tick (in_command/in_channel/
// in_reply_status). Results leave on out_strobe with out_event_kind,
// out_event_channel and out_last_event; each is held one cycle and the
// receiver cannot stall, so none is ever delayed by the far side.
// Configuration: cfg_we with cfg_index/cfg_wdata, written by the user only
// while idle; the block itself does not enforce this. Start and reply
// transactions leave busy low; a start result shows in the cycle after
// acceptance. A tick keeps busy high while one shared channel step unit
// visits one entry per cycle, except that an entry entering backoff also
// passes through the delay state before the next entry is visited, and a
// final flush state stages the last result. Results of a tick appear one per
// event; earlier ones show while busy is high, the last one, flagged by
// out_last_event, shows in the first cycle after busy falls.
// Reset sets all channels idle and loads the register defaults; it takes
// effect at once, with no clearing pass.
module retransmit_backoff_controller import rbc_pkg::*; #(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int DELAY_BITS = DEF_DELAY_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [1:0]  in_channel,
  input  logic [2:0]  in_reply_status,
  output logic        out_strobe,
  output logic [1:0]  out_event_kind,
  output logic [1:0]  out_event_channel,
  output logic        out_last_event,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DELAY, S_FLUSH} state_t;

  // Configuration registers
  logic [2:0]  retry_mode_r;
  logic [7:0]  max_retries_r;
  logic [15:0] reply_tmo_r;
  logic [15:0] backoff_unit_r;

  // Per-channel state
  logic [1:0]            phase_mem   [CHANNELS];
  logic [15:0]           reply_mem   [CHANNELS];
  logic [DELAY_BITS-1:0] backoff_mem [CHANNELS];
  logic [7:0]            retry_mem   [CHANNELS];
  logic [2:0]            status_mem  [CHANNELS];

  // Sequencer and output registers
  state_t        state_r, state_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [1:0]    pend_kind_r, pend_kind_nxt;
  logic [1:0]    pend_chan_r, pend_chan_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [1:0]    out_chan_r, out_chan_nxt;
  logic          out_last_r, out_last_nxt;

  // Entry access
  logic [CW-1:0]         in_ch_idx;
  logic                  in_range;
  logic [CW-1:0]         addr;
  logic                  scan_last;
  logic [1:0]            rd_phase;
  logic [15:0]           rd_reply;
  logic [DELAY_BITS-1:0] rd_backoff;
  logic [7:0]            rd_retry;
  logic [2:0]            rd_status;

  // Entry write controls
  logic                  wr_phase, wr_reply, wr_backoff, wr_retry, wr_status;
  logic [1:0]            phase_wdata;
  logic [15:0]           reply_wdata;
  logic [DELAY_BITS-1:0] backoff_wdata;
  logic [7:0]            retry_wdata;
  logic [2:0]            status_wdata;

  step_ctl_t             ctl;
  logic [DELAY_BITS-1:0] delay;

  assign in_ch_idx = CW'(in_channel);
  assign in_range  = 32'(in_channel) < 32'(CHANNELS);
  assign addr      = (state_r == S_IDLE) ? in_ch_idx : scan_r;
  assign scan_last = (scan_r == CW'(CHANNELS - 1));

  assign rd_phase   = phase_mem[addr];
  assign rd_reply   = reply_mem[addr];
  assign rd_backoff = backoff_mem[addr];
  assign rd_retry   = retry_mem[addr];
  assign rd_status  = status_mem[addr];

  rbc_step #(.DELAY_BITS(DELAY_BITS)) u_step (
    .phase      (rd_phase),
    .reply_cd   (rd_reply),
    .backoff_cd (rd_backoff),
    .retry_cnt  (rd_retry),
    .status     (rd_status),
    .retry_mode (retry_mode_r),
    .max_retries(max_retries_r),
    .ctl        (ctl)
  );

  rbc_delay #(.DELAY_BITS(DELAY_BITS)) u_delay (
    .retry_mode(retry_mode_r),
    .unit_ticks(backoff_unit_r),
    .retry_cnt (rd_retry),
    .delay     (delay)
  );

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = out_strobe_r;
  assign out_event_kind    = out_kind_r;
  assign out_event_channel = out_chan_r;
  assign out_last_event    = out_last_r;

  // Sequencer next state, entry updates and result staging
  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    pend_valid_nxt = pend_valid_r;
    pend_kind_nxt  = pend_kind_r;
    pend_chan_nxt  = pend_chan_r;
    out_strobe_nxt = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_chan_nxt   = out_chan_r;
    out_last_nxt   = out_last_r;
    wr_phase       = 1'b0;
    wr_reply       = 1'b0;
    wr_backoff     = 1'b0;
    wr_retry       = 1'b0;
    wr_status      = 1'b0;
    phase_wdata    = ctl.phase_nxt;
    reply_wdata    = reply_tmo_r;
    backoff_wdata  = delay;
    retry_wdata    = '0;
    status_wdata   = ST_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_command)
            CMD_START: begin
              if (in_range) begin
                wr_phase       = 1'b1;
                phase_wdata    = PH_REPLY;
                wr_reply       = 1'b1;
                wr_retry       = 1'b1;
                wr_status      = 1'b1;
                out_strobe_nxt = 1'b1;
                out_kind_nxt   = EV_SEND;
                out_chan_nxt   = in_channel;
                out_last_nxt   = 1'b1;
              end
            end
            CMD_REPLY: begin
              // store the status only while waiting for it
              if (in_range && rd_phase == PH_REPLY) begin
                wr_status    = 1'b1;
                status_wdata = in_reply_status;
              end
            end
            CMD_TICK: begin
              state_nxt      = S_SCAN;
              scan_nxt       = '0;
              pend_valid_nxt = 1'b0;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        wr_phase = 1'b1;
        if (ctl.dec_reply) begin
          wr_reply    = 1'b1;
          reply_wdata = rd_reply - 16'd1;
        end
        if (ctl.dec_backoff) begin
          wr_backoff    = 1'b1;
          backoff_wdata = rd_backoff - DELAY_BITS'(1);
        end
        if (ctl.load_send) begin
          wr_reply  = 1'b1;
          wr_status = 1'b1;
        end
        if (ctl.bump_retry) begin
          wr_retry    = 1'b1;
          retry_wdata = rd_retry + 8'd1;
        end
        // release the held result, hold the new one until we know if it is last
        if (ctl.ev_valid) begin
          if (pend_valid_r) begin
            out_strobe_nxt = 1'b1;
            out_kind_nxt   = pend_kind_r;
            out_chan_nxt   = pend_chan_r;
            out_last_nxt   = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_kind_nxt  = ctl.ev_kind;
          pend_chan_nxt  = 2'(scan_r);
        end
        if (ctl.need_delay) begin
          state_nxt = S_DELAY;
        end else if (scan_last) begin
          state_nxt = S_FLUSH;
        end else begin
          scan_nxt = scan_r + CW'(1);
        end
      end
      S_DELAY: begin
        wr_backoff = 1'b1;
        if (scan_last) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_SCAN;
          scan_nxt  = scan_r + CW'(1);
        end
      end
      S_FLUSH: begin
        if (pend_valid_r) begin
          out_strobe_nxt = 1'b1;
          out_kind_nxt   = pend_kind_r;
          out_chan_nxt   = pend_chan_r;
          out_last_nxt   = 1'b1;
        end
        pend_valid_nxt = 1'b0;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_r       <= '0;
      pend_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_r       <= scan_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    pend_kind_r <= pend_kind_nxt;
    pend_chan_r <= pend_chan_nxt;
    out_kind_r  <= out_kind_nxt;
    out_chan_r  <= out_chan_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Channel phases, all idle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase_mem[i] <= PH_IDLE;
      end
    end else if (wr_phase) begin
      phase_mem[addr] <= phase_wdata;
    end
  end

  // Channel timers, retry count and stored status
  always_ff @(posedge clk) begin
    if (wr_reply) begin
      reply_mem[addr] <= reply_wdata;
    end
    if (wr_backoff) begin
      backoff_mem[addr] <= backoff_wdata;
    end
    if (wr_retry) begin
      retry_mem[addr] <= retry_wdata;
    end
    if (wr_status) begin
      status_mem[addr] <= status_wdata;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_mode_r   <= RST_RETRY_MODE;
      max_retries_r  <= RST_MAX_RETRIES;
      reply_tmo_r    <= RST_REPLY_TMO;
      backoff_unit_r <= RST_BACKOFF_U;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RETRY_MODE:  retry_mode_r   <= cfg_wdata[2:0];
        CFG_MAX_RETRIES: max_retries_r  <= cfg_wdata[7:0];
        CFG_REPLY_TMO:   reply_tmo_r    <= cfg_wdata;
        CFG_BACKOFF_U:   backoff_unit_r <= cfg_wdata;
        default: begin
          retry_mode_r <= retry_mode_r;
        end
      endcase
    end
  end

endmodule
